// ===== rtl/mtg_pkg.sv =====
package mtg_pkg;

    // Operation codes carried by the op field
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_RESTART   = 3'd1;
    localparam logic [2:0] OP_WAVE_NEXT = 3'd2;
    localparam logic [2:0] OP_WAVE_PREV = 3'd3;
    localparam logic [2:0] OP_LOAD      = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_BEAT_TICKS     = 2'd0;
    localparam logic [1:0] CFG_WAVEFORM_TABLE = 2'd1;
    localparam logic [1:0] CFG_MELODY_POINTS  = 2'd2;

    localparam logic [15:0] BEAT_TICKS_RST     = 16'd1171;
    localparam logic [31:0] WAVEFORM_TABLE_RST = 32'd1975054336;
    localparam logic [5:0]  MELODY_POINTS_RST  = 6'd20;

    // Remainder unit: 7-bit dividend, one quotient bit per cycle
    localparam int DIV_STEPS = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_READ,
        ST_FETCH,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic capture;
        logic tick_apply;
        logic misc_apply;
        logic div_start;
        logic div_step;
        logic mem_read;
        logic fetch_apply;
        logic mem_write;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic op_tick;
        logic op_load;
        logic need_fetch;
        logic div_last;
        logic out_free;
    } status_t;

    // Timer period for each note nibble
    function automatic logic [7:0] divisions(input logic [3:0] nib);
        logic [7:0] d;
        case (nib)
            4'd0:    d = 8'd255;
            4'd1:    d = 8'd200;
            4'd2:    d = 8'd193;
            4'd3:    d = 8'd185;
            4'd4:    d = 8'd181;
            4'd5:    d = 8'd171;
            4'd6:    d = 8'd209;
            4'd7:    d = 8'd203;
            4'd8:    d = 8'd143;
            4'd9:    d = 8'd129;
            4'd10:   d = 8'd113;
            4'd11:   d = 8'd104;
            4'd12:   d = 8'd86;
            4'd13:   d = 8'd161;
            4'd14:   d = 8'd149;
            default: d = 8'd255;
        endcase
        return d;
    endfunction

    // Period divided by nine, one entry per nibble
    function automatic logic [7:0] step_of(input logic [3:0] nib);
        logic [7:0] s;
        case (nib)
            4'd0:    s = 8'd28;
            4'd1:    s = 8'd22;
            4'd2:    s = 8'd21;
            4'd3:    s = 8'd20;
            4'd4:    s = 8'd20;
            4'd5:    s = 8'd19;
            4'd6:    s = 8'd23;
            4'd7:    s = 8'd22;
            4'd8:    s = 8'd15;
            4'd9:    s = 8'd14;
            4'd10:   s = 8'd12;
            4'd11:   s = 8'd11;
            4'd12:   s = 8'd9;
            4'd13:   s = 8'd17;
            4'd14:   s = 8'd16;
            default: s = 8'd28;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/mtg_divmod.sv =====
module mtg_divmod (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  logic       step,
    input  logic [6:0] dividend,
    input  logic [7:0] divisor,
    output logic [7:0] remainder,
    output logic       last
);

    logic [7:0] rem_reg, rem_next;
    logic [6:0] quo_reg, quo_next;
    logic [7:0] dsr_reg, dsr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [7:0] shifted;

    always_comb begin
        shifted  = {rem_reg[6:0], quo_reg[6]};
        rem_next = rem_reg;
        quo_next = quo_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
            cnt_next = '0;
        end else if (step) begin
            // restoring step: remainder stays below divisor, so 8 bits hold the shift
            rem_next = (shifted >= dsr_reg) ? shifted - dsr_reg : shifted;
            quo_next = {quo_reg[5:0], 1'b0};
            cnt_next = cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign remainder = rem_reg;
    assign last      = (cnt_reg == 3'(mtg_pkg::DIV_STEPS - 1));

endmodule

// ===== rtl/mtg_datapath.sv =====
module mtg_datapath #(
    parameter int MELODY_DEPTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  mtg_pkg::cmd_t    cmd,
    output mtg_pkg::status_t status,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_wdata,
    input  logic [2:0]       s_op,
    input  logic [4:0]       s_load_address,
    input  logic [7:0]       s_load_data,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_audio_level,
    output logic             m_note_fetched
);

    localparam int         AW      = $clog2(MELODY_DEPTH);
    localparam logic [7:0] DEPTH_W = 8'(MELODY_DEPTH);

    typedef logic [31:0][7:0] wrap_tab_t;

    // Store slot for every load address, wrapped into the melody depth
    function automatic wrap_tab_t build_wrap();
        wrap_tab_t t;
        for (int i = 0; i < 32; i++) begin
            t[i] = 8'(i % MELODY_DEPTH);
        end
        return t;
    endfunction

    localparam wrap_tab_t ADDR_WRAP = build_wrap();

    logic [15:0] beat_ticks_reg;
    logic [31:0] waveform_table_reg;
    logic [5:0]  melody_points_reg;

    logic [2:0] op_reg;
    logic [4:0] addr_reg;
    logic [7:0] data_reg;

    logic [7:0]  tick_counter_reg, tick_counter_next;
    logic [7:0]  period_reg, period_next;
    logic [7:0]  step_cmp_reg, step_cmp_next;
    logic [7:0]  step_size_reg, step_size_next;
    logic [7:0]  live_pat_reg, live_pat_next;
    logic        level_reg, level_next;
    logic [15:0] beat_acc_reg, beat_acc_next;
    logic [7:0]  note_index_reg, note_index_next;
    logic [1:0]  wave_sel_reg, wave_sel_next;
    logic [7:0]  note_pat_reg, note_pat_next;
    logic        fetched_reg, fetched_next;

    logic        m_valid_reg, m_valid_next;
    logic        m_level_reg;
    logic        m_fetched_reg;

    logic [7:0]  melody_mem [MELODY_DEPTH];
    logic [7:0]  rd_data_reg;
    logic [7:0]  wr_slot;

    logic [7:0]  cnt_tick;
    logic        step_hit, period_hit;
    logic [16:0] acc_sum;
    logic [15:0] acc_sat;
    logic        beat_ge;
    logic [7:0]  points_ext, count;
    logic [6:0]  div_dividend;
    logic [7:0]  div_divisor;
    logic [7:0]  remainder;
    logic        div_last;
    logic [3:0]  nib;
    logic [7:0]  new_pat;

    // Config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_ticks_reg     <= mtg_pkg::BEAT_TICKS_RST;
            waveform_table_reg <= mtg_pkg::WAVEFORM_TABLE_RST;
            melody_points_reg  <= mtg_pkg::MELODY_POINTS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                mtg_pkg::CFG_BEAT_TICKS:     beat_ticks_reg     <= cfg_wdata[15:0];
                mtg_pkg::CFG_WAVEFORM_TABLE: waveform_table_reg <= cfg_wdata;
                mtg_pkg::CFG_MELODY_POINTS:  melody_points_reg  <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= s_op;
            addr_reg <= s_load_address;
            data_reg <= s_load_data;
        end
    end

    // Timer compare logic
    always_comb begin
        cnt_tick   = (tick_counter_reg == period_reg) ? 8'd0 : tick_counter_reg + 8'd1;
        step_hit   = (cnt_tick == step_cmp_reg);
        period_hit = (cnt_tick == period_reg);
        acc_sum    = {1'b0, beat_acc_reg} + {9'd0, period_reg};
        acc_sat    = acc_sum[16] ? 16'hFFFF : acc_sum[15:0];
        beat_ge    = (acc_sat >= beat_ticks_reg);
    end

    // Melody length clamp and remainder operands
    always_comb begin
        points_ext = {2'b00, melody_points_reg};
        if (points_ext == 8'd0) begin
            count = 8'd1;
        end else if (points_ext > DEPTH_W) begin
            count = DEPTH_W;
        end else begin
            count = points_ext;
        end
        div_dividend = note_index_reg[7:1];
        div_divisor  = count;
    end

    mtg_divmod u_divmod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .step      (cmd.div_step),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .remainder (remainder),
        .last      (div_last)
    );

    assign wr_slot = ADDR_WRAP[addr_reg];

    always_ff @(posedge aclk) begin
        if (cmd.mem_write) begin
            melody_mem[wr_slot[AW-1:0]] <= data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_read) begin
            rd_data_reg <= melody_mem[remainder[AW-1:0]];
        end
    end

    always_comb begin
        nib     = note_index_reg[0] ? rd_data_reg[3:0] : rd_data_reg[7:4];
        new_pat = (nib != 4'd0) ? waveform_table_reg[{wave_sel_reg, 3'b000} +: 8] : 8'd0;
    end

    always_comb begin
        tick_counter_next = tick_counter_reg;
        period_next       = period_reg;
        step_cmp_next     = step_cmp_reg;
        step_size_next    = step_size_reg;
        live_pat_next     = live_pat_reg;
        level_next        = level_reg;
        beat_acc_next     = beat_acc_reg;
        note_index_next   = note_index_reg;
        wave_sel_next     = wave_sel_reg;
        note_pat_next     = note_pat_reg;
        fetched_next      = fetched_reg;

        if (cmd.capture) begin
            fetched_next = 1'b0;
        end

        if (cmd.tick_apply) begin
            tick_counter_next = cnt_tick;
            if (step_hit) begin
                level_next    = live_pat_reg[0];
                live_pat_next = {1'b0, live_pat_reg[7:1]};
                step_cmp_next = step_cmp_reg + step_size_reg;
            end
            if (period_hit) begin
                if (beat_ge) begin
                    // period restart waits for the new note
                    beat_acc_next = 16'd0;
                end else begin
                    beat_acc_next = acc_sat;
                    level_next    = 1'b0;
                    live_pat_next = note_pat_reg;
                    step_cmp_next = step_size_reg;
                end
            end
        end

        if (cmd.misc_apply) begin
            case (op_reg)
                mtg_pkg::OP_RESTART:   note_index_next = 8'd0;
                mtg_pkg::OP_WAVE_NEXT: wave_sel_next   = wave_sel_reg + 2'd1;
                mtg_pkg::OP_WAVE_PREV: wave_sel_next   = wave_sel_reg - 2'd1;
                default: ;
            endcase
        end

        if (cmd.fetch_apply) begin
            note_index_next = note_index_reg + 8'd1;
            period_next     = mtg_pkg::divisions(nib);
            step_size_next  = mtg_pkg::step_of(nib);
            note_pat_next   = new_pat;
            level_next      = 1'b0;
            live_pat_next   = new_pat;
            step_cmp_next   = mtg_pkg::step_of(nib);
            fetched_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_counter_reg <= '0;
            period_reg       <= '0;
            step_cmp_reg     <= '0;
            step_size_reg    <= '0;
            live_pat_reg     <= '0;
            level_reg        <= 1'b0;
            beat_acc_reg     <= 16'hFFFF;
            note_index_reg   <= '0;
            wave_sel_reg     <= '0;
            note_pat_reg     <= '0;
            fetched_reg      <= 1'b0;
        end else begin
            tick_counter_reg <= tick_counter_next;
            period_reg       <= period_next;
            step_cmp_reg     <= step_cmp_next;
            step_size_reg    <= step_size_next;
            live_pat_reg     <= live_pat_next;
            level_reg        <= level_next;
            beat_acc_reg     <= beat_acc_next;
            note_index_reg   <= note_index_next;
            wave_sel_reg     <= wave_sel_next;
            note_pat_reg     <= note_pat_next;
            fetched_reg      <= fetched_next;
        end
    end

    // Result register; loads the post-item level and fetch flag
    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (cmd.load_out) begin
            m_level_reg   <= level_next;
            m_fetched_reg <= fetched_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_audio_level  = m_level_reg;
    assign m_note_fetched = m_fetched_reg;

    always_comb begin
        status.op_tick    = (op_reg == mtg_pkg::OP_TICK);
        status.op_load    = (op_reg == mtg_pkg::OP_LOAD);
        status.need_fetch = period_hit && beat_ge;
        status.div_last   = div_last;
        status.out_free   = !m_valid_reg || m_ready;
    end

endmodule

// ===== rtl/mtg_controller.sv =====
module mtg_controller (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  mtg_pkg::status_t status,
    output mtg_pkg::cmd_t    cmd
);

    mtg_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mtg_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            mtg_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = mtg_pkg::ST_EXEC;
                end
            end
            mtg_pkg::ST_EXEC: begin
                if (status.op_tick && status.need_fetch) begin
                    cmd.tick_apply = 1'b1;
                    cmd.div_start  = 1'b1;
                    state_next     = mtg_pkg::ST_DIV;
                end else begin
                    cmd.tick_apply = status.op_tick;
                    cmd.misc_apply = !status.op_tick;
                    cmd.mem_write  = status.op_load;
                    cmd.load_out   = status.out_free;
                    state_next     = status.out_free ? mtg_pkg::ST_IDLE : mtg_pkg::ST_RESP;
                end
            end
            mtg_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = mtg_pkg::ST_READ;
                end
            end
            mtg_pkg::ST_READ: begin
                cmd.mem_read = 1'b1;
                state_next   = mtg_pkg::ST_FETCH;
            end
            mtg_pkg::ST_FETCH: begin
                cmd.fetch_apply = 1'b1;
                cmd.load_out    = status.out_free;
                state_next      = status.out_free ? mtg_pkg::ST_IDLE : mtg_pkg::ST_RESP;
            end
            mtg_pkg::ST_RESP: begin
                // hold until the result register frees up
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = mtg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mtg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/melody_tone_generator.sv =====
// One-bit melody player stepped by timer ticks: every tick op advances an 8-bit
// clear-on-compare counter, shifts the waveform pattern onto audio_level at step
// matches and, once the beat accumulator reaches beat_ticks, fetches the next
// melody nibble. A tick that does not fetch passes through accept and execute; a
// tick that fetches then runs the 7-step remainder unit that wraps the note
// position into the melody length, the registered melody memory read and a note
// apply state. A melody byte load and the other ops pass through accept and
// execute; the load address wraps into the store through a fixed lookup. The
// next beat is accepted while a result waits in the output register; the result
// is delivered one item at a time in order. Melody bytes read back undefined
// until loaded.
module melody_tone_generator #(
    parameter int MELODY_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [4:0]  s_load_address,
    input  logic [7:0]  s_load_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_audio_level,
    output logic        m_note_fetched
);

    mtg_pkg::cmd_t    cmd;
    mtg_pkg::status_t status;

    mtg_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mtg_datapath #(
        .MELODY_DEPTH (MELODY_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_op           (s_op),
        .s_load_address (s_load_address),
        .s_load_data    (s_load_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_audio_level  (m_audio_level),
        .m_note_fetched (m_note_fetched)
    );

    // a fetch restarts the period with the level low
    a_fetch_level_low : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_note_fetched) |-> !m_audio_level)
        else $error("note fetch result with audio level high");

    // never overwrite a result that has not been taken
    a_load_out_free : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("result register loaded while occupied");

    // note apply uses the memory data read the cycle before
    a_fetch_after_read : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fetch_apply |-> $past(cmd.mem_read))
        else $error("note applied without a preceding memory read");

endmodule

// ===== tb/melody_tone_generator_test.sv =====
module melody_tone_generator_test;

    localparam int MEL_DEPTH = 32;

    // ops 5 to 7 have no meaning and must leave the state alone
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_MID   = 3'd6;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam logic [7:0] NOTE_PERIOD [16] = '{
        8'd255, 8'd200, 8'd193, 8'd185, 8'd181, 8'd171, 8'd209, 8'd203,
        8'd143, 8'd129, 8'd113, 8'd104, 8'd86,  8'd161, 8'd149, 8'd255
    };

    typedef struct {
        logic [2:0] op;
        logic [4:0] addr;
        logic [7:0] data;
    } cmd_item_t;

    typedef struct {
        logic level;
        logic fetched;
    } sample_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_op;
    logic [4:0]  s_load_address;
    logic [7:0]  s_load_data;
    logic        m_valid;
    logic        m_ready;
    logic        m_audio_level;
    logic        m_note_fetched;

    cmd_item_t pending_cmds[$];
    sample_t   predicted_samples[$];
    int        errors = 0;
    int        send_gap = 0;
    int        recv_gap = 0;
    logic      calm = 1'b0;

    // register shadows
    logic [15:0] beat_len;
    logic [31:0] wave_table;
    logic [5:0]  melody_pts;

    // player state
    logic [7:0]  tmr_count = 8'd0;
    logic [7:0]  tmr_period = 8'd0;
    logic [7:0]  tmr_step_cmp = 8'd0;
    logic [7:0]  step_inc = 8'd0;
    logic [7:0]  shift_pat = 8'd0;
    logic [7:0]  note_pat = 8'd0;
    logic        audio = 1'b0;
    logic [15:0] beat_acc = 16'hFFFF;
    logic [7:0]  note_pos = 8'd0;
    logic [1:0]  wave_sel = 2'd0;
    logic [7:0]  melody_mem [MEL_DEPTH] = '{default: 8'd0};

    melody_tone_generator #(.MELODY_DEPTH(MEL_DEPTH)) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_load_address (s_load_address),
        .s_load_data    (s_load_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_audio_level  (m_audio_level),
        .m_note_fetched (m_note_fetched)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic fetch_next_note;
        int         span;
        int         slot;
        logic [7:0] packed_notes;
        logic [3:0] nib;
        span = (melody_pts == 6'd0) ? 1 : (melody_pts > MEL_DEPTH) ? MEL_DEPTH : int'(melody_pts);
        slot = int'(note_pos >> 1) % span;
        packed_notes = melody_mem[slot];
        nib = note_pos[0] ? packed_notes[3:0] : packed_notes[7:4];
        note_pos = note_pos + 8'd1;
        tmr_period = NOTE_PERIOD[nib];
        step_inc = tmr_period / 8'd9;
        note_pat = (nib != 4'd0) ? wave_table[8 * wave_sel +: 8] : 8'd0;
    endtask

    task automatic play_command(input cmd_item_t c);
        sample_t     s;
        logic        step_match;
        logic        period_match;
        logic [16:0] sum;
        s.fetched = 1'b0;
        case (c.op)
            mtg_pkg::OP_TICK: begin
                if (tmr_count == tmr_period) tmr_count = 8'd0;
                else tmr_count = tmr_count + 8'd1;
                step_match = (tmr_count == tmr_step_cmp);
                period_match = (tmr_count == tmr_period);
                if (step_match) begin
                    audio = shift_pat[0];
                    shift_pat = shift_pat >> 1;
                    tmr_step_cmp = tmr_step_cmp + step_inc;
                end
                if (period_match) begin
                    // saturate the beat accumulator
                    sum = {1'b0, beat_acc} + {9'd0, tmr_period};
                    beat_acc = sum[16] ? 16'hFFFF : sum[15:0];
                    if (beat_acc >= beat_len) begin
                        beat_acc = 16'd0;
                        fetch_next_note();
                        s.fetched = 1'b1;
                    end
                    audio = 1'b0;
                    shift_pat = note_pat;
                    tmr_step_cmp = step_inc;
                end
            end
            mtg_pkg::OP_RESTART:   note_pos = 8'd0;
            mtg_pkg::OP_WAVE_NEXT: wave_sel = wave_sel + 2'd1;
            mtg_pkg::OP_WAVE_PREV: wave_sel = wave_sel - 2'd1;
            mtg_pkg::OP_LOAD:      melody_mem[c.addr % MEL_DEPTH] = c.data;
            default: ;
        endcase
        s.level = audio;
        predicted_samples.push_back(s);
    endtask

    // driver: one beat per handshake, random bursts of idle cycles between beats
    always @(posedge aclk) begin
        cmd_item_t c;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_op <= mtg_pkg::OP_TICK;
            s_load_address <= 5'd0;
            s_load_data <= 8'd0;
        end else begin
            if (s_valid && s_ready) begin
                c.op = s_op;
                c.addr = s_load_address;
                c.data = s_load_data;
                play_command(c);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    c = pending_cmds.pop_front();
                    s_valid <= 1'b1;
                    s_op <= c.op;
                    s_load_address <= c.addr;
                    s_load_data <= c.data;
                    if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 7);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each output beat with the oldest prediction
    always @(posedge aclk) begin
        sample_t s;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid === 1'b1 && m_ready) begin
                if (predicted_samples.size() == 0) begin
                    errors++;
                    $display("%0t: output beat with nothing expected: level %0b fetched %0b",
                             $time, m_audio_level, m_note_fetched);
                end else begin
                    s = predicted_samples.pop_front();
                    if (m_audio_level !== s.level) begin
                        errors++;
                        $display("%0t: audio_level expected %0b actual %0b",
                                 $time, s.level, m_audio_level);
                    end
                    if (m_note_fetched !== s.fetched) begin
                        errors++;
                        $display("%0t: note_fetched expected %0b actual %0b",
                                 $time, s.fetched, m_note_fetched);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            mtg_pkg::CFG_BEAT_TICKS:     beat_len = val[15:0];
            mtg_pkg::CFG_WAVEFORM_TABLE: wave_table = val;
            mtg_pkg::CFG_MELODY_POINTS:  melody_pts = val[5:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_cmd(input logic [2:0] op, input logic [4:0] addr, input logic [7:0] data);
        cmd_item_t c;
        c.op = op;
        c.addr = addr;
        c.data = data;
        pending_cmds.push_back(c);
    endtask

    // mostly ticks, so that periods end and notes get fetched
    task automatic add_random_cmds(input int n);
        int         pick;
        logic [2:0] op;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 88) op = mtg_pkg::OP_TICK;
            else if (pick < 90) op = mtg_pkg::OP_RESTART;
            else if (pick < 93) op = mtg_pkg::OP_WAVE_NEXT;
            else if (pick < 95) op = mtg_pkg::OP_WAVE_PREV;
            else if (pick < 98) op = mtg_pkg::OP_LOAD;
            else op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            add_cmd(op, 5'($urandom), 8'($urandom));
        end
    endtask

    // hold until every beat is sent and every output has been checked
    task automatic wait_drained;
        @(negedge aclk);
        while (pending_cmds.size() != 0 || s_valid || predicted_samples.size() != 0)
            @(negedge aclk);
    endtask

    initial begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [3:0] hi;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = mtg_pkg::CFG_BEAT_TICKS;
        cfg_wdata = 32'd0;

        beat_len = mtg_pkg::BEAT_TICKS_RST;
        wave_table = mtg_pkg::WAVEFORM_TABLE_RST;
        melody_pts = mtg_pkg::MELODY_POINTS_RST;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // fill the whole melody store first; the first eight bytes hold every nibble
        for (int i = 0; i < MEL_DEPTH; i++) begin
            hi = 4'(2 * i);
            add_cmd(mtg_pkg::OP_LOAD, 5'(i), (i < 8) ? {hi, hi + 4'd1} : 8'($urandom));
        end

        // first tick fetches at once, since the beat accumulator starts at its maximum
        add_cmd(mtg_pkg::OP_TICK, 5'd31, 8'hFF);
        add_cmd(mtg_pkg::OP_TICK, 5'd0, 8'h00);
        add_cmd(OP_SPARE_FIRST, 5'd31, 8'hFF);
        add_cmd(OP_SPARE_MID, 5'd0, 8'h00);
        add_cmd(OP_SPARE_LAST, 5'd21, 8'hA5);
        add_cmd(mtg_pkg::OP_WAVE_PREV, 5'd0, 8'h00);
        add_cmd(mtg_pkg::OP_WAVE_PREV, 5'd0, 8'h00);
        add_cmd(mtg_pkg::OP_WAVE_NEXT, 5'd0, 8'h00);
        add_cmd(mtg_pkg::OP_WAVE_NEXT, 5'd0, 8'h00);
        add_cmd(mtg_pkg::OP_WAVE_NEXT, 5'd0, 8'h00);
        add_cmd(mtg_pkg::OP_RESTART, 5'd10, 8'h5A);
        add_cmd(mtg_pkg::OP_LOAD, 5'd31, 8'hFF);
        add_cmd(mtg_pkg::OP_LOAD, 5'd0, 8'h0F);
        add_cmd(mtg_pkg::OP_LOAD, 5'd1, 8'h00);
        for (int i = 0; i < 8; i++) add_cmd(mtg_pkg::OP_TICK, 5'($urandom), 8'($urandom));
        add_random_cmds(80);
        wait_drained();

        // beat length zero, every pattern bit set, melody count zero
        write_reg(mtg_pkg::CFG_BEAT_TICKS, 32'd0);
        write_reg(mtg_pkg::CFG_WAVEFORM_TABLE, 32'hFFFF_FFFF);
        write_reg(mtg_pkg::CFG_MELODY_POINTS, 32'd0);
        add_random_cmds(60);
        wait_drained();

        write_reg(mtg_pkg::CFG_BEAT_TICKS, 32'd1);
        write_reg(mtg_pkg::CFG_WAVEFORM_TABLE, 32'd0);
        write_reg(mtg_pkg::CFG_MELODY_POINTS, 32'd63);
        add_random_cmds(60);
        wait_drained();

        write_reg(mtg_pkg::CFG_BEAT_TICKS, 32'd65535);
        write_reg(mtg_pkg::CFG_WAVEFORM_TABLE, $urandom);
        write_reg(mtg_pkg::CFG_MELODY_POINTS, 32'd32);
        add_random_cmds(40);
        wait_drained();

        write_reg(mtg_pkg::CFG_BEAT_TICKS, 32'd1);
        write_reg(mtg_pkg::CFG_WAVEFORM_TABLE, $urandom);
        write_reg(mtg_pkg::CFG_MELODY_POINTS, 32'd1);
        add_random_cmds(60);
        wait_drained();

        // last stretch runs back to back with no idling on either side
        calm = 1'b1;
        write_reg(mtg_pkg::CFG_BEAT_TICKS, 32'($urandom_range(0, 300)));
        write_reg(mtg_pkg::CFG_WAVEFORM_TABLE, $urandom);
        write_reg(mtg_pkg::CFG_MELODY_POINTS, 32'd33);
        add_random_cmds(50);
        wait_drained();

        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
